// ----- design/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// JSON string unescaper package
// Shared result codes, character codes, types and helper functions.
// ----------------------------------------------------------------------------
package jsu_pkg;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [15:0] LENGTH_MAX = 16'hffff;

	// Depth of the queue between the decoder and the result serializer.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_LB     = 8'h62;
	localparam logic [7:0] CH_LF     = 8'h66;
	localparam logic [7:0] CH_LN     = 8'h6e;
	localparam logic [7:0] CH_LR     = 8'h72;
	localparam logic [7:0] CH_LT     = 8'h74;
	localparam logic [7:0] CH_LU     = 8'h75;

	typedef enum logic [7:0] {
		M_IDLE    = 8'b0000_0001,
		M_STR     = 8'b0000_0010,
		M_ESC     = 8'b0000_0100,
		M_HEX     = 8'b0000_1000,
		M_WAIT_BS = 8'b0001_0000,
		M_WAIT_U  = 8'b0010_0000,
		M_HEX_LOW = 8'b0100_0000,
		M_UTF8    = 8'b1000_0000
	} mode_t;

	// One group of results caused by one input beat.
	typedef struct packed {
		logic [1:0]      kind;
		logic [1:0]      last_idx;
		logic [3:0][7:0] bytes;
		logic [15:0]     len;
	} res_grp_t;

	typedef struct packed {
		logic [2:0]      cnt;
		logic [3:0][7:0] bytes;
	} enc_t;

	// Returns {valid, value} for an ASCII hex digit.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, 4'(c[3:0] + 4'd9)};
		end
		return r;
	endfunction

	// UTF-8 encoding of a code point; bytes[0] goes out first.
	function automatic enc_t utf8_encode(input logic [20:0] code);
		enc_t e;
		e = '0;
		if (code < 21'h80) begin
			e.cnt = 3'd1;
			e.bytes[0] = code[7:0];
		end else if (code < 21'h800) begin
			e.cnt = 3'd2;
			e.bytes[0] = {3'b110, code[10:6]};
			e.bytes[1] = {2'b10, code[5:0]};
		end else if (code < 21'h10000) begin
			e.cnt = 3'd3;
			e.bytes[0] = {4'b1110, code[15:12]};
			e.bytes[1] = {2'b10, code[11:6]};
			e.bytes[2] = {2'b10, code[5:0]};
		end else begin
			e.cnt = 3'd4;
			e.bytes[0] = {5'b11110, code[20:18]};
			e.bytes[1] = {2'b10, code[17:12]};
			e.bytes[2] = {2'b10, code[11:6]};
			e.bytes[3] = {2'b10, code[5:0]};
		end
		return e;
	endfunction

endpackage

// ----- design/jsu_in_if.sv -----
// ----------------------------------------------------------------------------
// JSON text input channel
// One beat carries an opcode and one raw text byte.
// ----------------------------------------------------------------------------
interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] in_byte;

	modport source (output valid, output opcode, output in_byte, input ready);
	modport sink (input valid, input opcode, input in_byte, output ready);
endinterface

// ----- design/jsu_out_if.sv -----
// ----------------------------------------------------------------------------
// Decoded result channel
// One beat carries one decoded byte, an end marker or an error.
// ----------------------------------------------------------------------------
interface jsu_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [7:0]  out_byte;
	logic [15:0] decoded_length;
	logic        last;

	modport source (output valid, output result_kind, output out_byte,
		output decoded_length, output last, input ready);
	modport sink (input valid, input result_kind, input out_byte,
		input decoded_length, input last, output ready);
endinterface

// ----- design/jsu_front.sv -----
// ----------------------------------------------------------------------------
// Unescaper decoder
// Accepts text beats, runs the string state machine and pushes one result
// group per beat that produces output.
// ----------------------------------------------------------------------------
module jsu_front import jsu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	jsu_in_if.sink   text,
	output logic     push,
	output res_grp_t grp,
	input  logic     full
);

	mode_t       mode_q, mode_n;
	logic [15:0] acc_q, acc_n;
	logic [1:0]  cnt_q, cnt_n;
	logic [9:0]  hi_q, hi_n;
	logic [23:0] held_q, held_n;
	logic [1:0]  need_q, need_n;
	logic [1:0]  nheld_q, nheld_n;
	logic [15:0] len_q, len_n;

	logic            fire;
	logic            fail_c;
	logic            end_c;
	logic [2:0]      emit_n;
	logic [3:0][7:0] emit_b;
	logic [4:0]      hv;
	logic [15:0]     acc_sh;
	logic [7:0]      b;
	logic [15:0]     code3;
	logic [20:0]     code4;
	logic [20:0]     pair_cp;
	logic [16:0]     len_sum;
	enc_t            enc16;
	enc_t            enc21;

	assign text.ready = !full;
	assign fire = text.valid && !full;
	assign b = text.in_byte;
	assign hv = hex_value(b);
	assign acc_sh = {acc_q[11:0], hv[3:0]};
	assign code3 = {held_q[11:8], held_q[5:0], b[5:0]};
	assign code4 = {held_q[18:16], held_q[13:8], held_q[5:0], b[5:0]};
	assign pair_cp = 21'h10000 + {1'b0, hi_q, acc_sh[9:0]};
	assign enc16 = utf8_encode({5'd0, acc_sh});
	assign enc21 = utf8_encode(pair_cp);
	assign len_sum = {1'b0, len_q} + {14'd0, emit_n};

	always_comb begin
		mode_n  = mode_q;
		acc_n   = acc_q;
		cnt_n   = cnt_q;
		hi_n    = hi_q;
		held_n  = held_q;
		need_n  = need_q;
		nheld_n = nheld_q;
		len_n   = len_q;
		fail_c  = 1'b0;
		end_c   = 1'b0;
		emit_n  = 3'd0;
		emit_b  = '0;
		if (text.opcode) begin
			fail_c = 1'b1;
		end else begin
			case (mode_q)
				M_IDLE: begin
					if (b == CH_QUOTE) mode_n = M_STR;
					else fail_c = 1'b1;
				end
				M_STR: begin
					if (b == CH_QUOTE) begin
						end_c = 1'b1;
					end else if (b < 8'h20) begin
						fail_c = 1'b1;
					end else if (b == CH_BSLASH) begin
						mode_n = M_ESC;
					end else if (b[7]) begin
						held_n  = {16'd0, b};
						nheld_n = 2'd1;
						mode_n  = M_UTF8;
						if (b >= 8'hc2 && b <= 8'hdf) need_n = 2'd1;
						else if (b >= 8'he0 && b <= 8'hef) need_n = 2'd2;
						else if (b >= 8'hf0 && b <= 8'hf4) need_n = 2'd3;
						else fail_c = 1'b1;
					end else begin
						emit_n = 3'd1;
						emit_b[0] = b;
					end
				end
				M_ESC: begin
					mode_n = M_STR;
					emit_n = 3'd1;
					case (b)
						CH_QUOTE, CH_BSLASH, CH_SLASH: emit_b[0] = b;
						CH_LB: emit_b[0] = 8'h08;
						CH_LF: emit_b[0] = 8'h0c;
						CH_LN: emit_b[0] = 8'h0a;
						CH_LR: emit_b[0] = 8'h0d;
						CH_LT: emit_b[0] = 8'h09;
						CH_LU: begin
							emit_n = 3'd0;
							acc_n  = '0;
							cnt_n  = '0;
							mode_n = M_HEX;
						end
						default: begin
							emit_n = 3'd0;
							fail_c = 1'b1;
						end
					endcase
				end
				M_HEX: begin
					if (!hv[4]) begin
						fail_c = 1'b1;
					end else if (cnt_q != 2'd3) begin
						acc_n = acc_sh;
						cnt_n = cnt_q + 2'd1;
					end else begin
						acc_n = '0;
						cnt_n = '0;
						if (acc_sh >= 16'hd800 && acc_sh <= 16'hdbff) begin
							hi_n   = acc_sh[9:0];
							mode_n = M_WAIT_BS;
						end else if (acc_sh >= 16'hdc00 && acc_sh <= 16'hdfff) begin
							fail_c = 1'b1;
						end else begin
							emit_n = enc16.cnt;
							emit_b = enc16.bytes;
							mode_n = M_STR;
						end
					end
				end
				M_WAIT_BS: begin
					if (b == CH_BSLASH) mode_n = M_WAIT_U;
					else fail_c = 1'b1;
				end
				M_WAIT_U: begin
					if (b == CH_LU) begin
						acc_n  = '0;
						cnt_n  = '0;
						mode_n = M_HEX_LOW;
					end else begin
						fail_c = 1'b1;
					end
				end
				M_HEX_LOW: begin
					if (!hv[4]) begin
						fail_c = 1'b1;
					end else if (cnt_q != 2'd3) begin
						acc_n = acc_sh;
						cnt_n = cnt_q + 2'd1;
					end else if (acc_sh < 16'hdc00 || acc_sh > 16'hdfff) begin
						fail_c = 1'b1;
					end else begin
						acc_n  = '0;
						cnt_n  = '0;
						hi_n   = '0;
						emit_n = enc21.cnt;
						emit_b = enc21.bytes;
						mode_n = M_STR;
					end
				end
				M_UTF8: begin
					if (b[7:6] != 2'b10 || nheld_q == 2'd0) begin
						fail_c = 1'b1;
					end else if (need_q > 2'd1) begin
						held_n  = {held_q[15:0], b};
						nheld_n = nheld_q + 2'd1;
						need_n  = need_q - 2'd1;
					end else begin
						// The sequence is complete: check it, then pass it through.
						case (nheld_q)
							2'd1: begin
								emit_n = 3'd2;
								emit_b = {16'd0, b, held_q[7:0]};
							end
							2'd2: begin
								if (code3 < 16'h800 || (code3 >= 16'hd800 && code3 <= 16'hdfff))
									fail_c = 1'b1;
								else begin
									emit_n = 3'd3;
									emit_b = {8'd0, b, held_q[7:0], held_q[15:8]};
								end
							end
							default: begin
								if (code4 < 21'h10000 || code4 > 21'h10ffff)
									fail_c = 1'b1;
								else begin
									emit_n = 3'd4;
									emit_b = {b, held_q[7:0], held_q[15:8], held_q[23:16]};
								end
							end
						endcase
						if (!fail_c) begin
							held_n  = '0;
							nheld_n = '0;
							need_n  = '0;
							mode_n  = M_STR;
						end
					end
				end
				default: fail_c = 1'b1;
			endcase
		end

		if (emit_n != 3'd0) begin
			len_n = (len_sum >= {1'b0, LENGTH_MAX}) ? LENGTH_MAX : len_sum[15:0];
		end
		if (fail_c || end_c) begin
			mode_n  = M_IDLE;
			acc_n   = '0;
			cnt_n   = '0;
			hi_n    = '0;
			held_n  = '0;
			need_n  = '0;
			nheld_n = '0;
			len_n   = '0;
		end
	end

	always_comb begin
		grp = '0;
		if (fail_c) begin
			grp.kind = KIND_ERR;
		end else if (end_c) begin
			grp.kind = KIND_END;
			grp.len  = len_q;
		end else begin
			grp.kind     = KIND_DATA;
			grp.last_idx = 2'(emit_n - 3'd1);
			grp.bytes    = emit_b;
		end
	end

	assign push = fire && (fail_c || end_c || emit_n != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			acc_q   <= '0;
			cnt_q   <= '0;
			hi_q    <= '0;
			held_q  <= '0;
			need_q  <= '0;
			nheld_q <= '0;
			len_q   <= '0;
		end else if (fire) begin
			mode_q  <= mode_n;
			acc_q   <= acc_n;
			cnt_q   <= cnt_n;
			hi_q    <= hi_n;
			held_q  <= held_n;
			need_q  <= need_n;
			nheld_q <= nheld_n;
			len_q   <= len_n;
		end
	end

endmodule

// ----- design/jsu_fifo.sv -----
// ----------------------------------------------------------------------------
// Result group queue
// Small register queue that decouples the decoder from the serializer.
// ----------------------------------------------------------------------------
module jsu_fifo import jsu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  res_grp_t wdata,
	output logic     full,
	input  logic     pop,
	output res_grp_t rdata,
	output logic     empty
);

	res_grp_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wptr_q;
	logic [QPTR_W-1:0]   rptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = count_q == QCNT_W'(QDEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (do_pop) rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- design/jsu_back.sv -----
// ----------------------------------------------------------------------------
// Result serializer
// Sends the results of the head group one beat at a time and marks the last.
// ----------------------------------------------------------------------------
module jsu_back import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  res_grp_t   head,
	input  logic       empty,
	output logic       pop,
	jsu_out_if.source  result
);

	logic [1:0] idx_q;
	logic       is_last;
	logic       fire;

	assign is_last = idx_q == head.last_idx;
	assign fire    = result.valid && result.ready;
	assign pop     = fire && is_last;

	assign result.valid          = !empty;
	assign result.result_kind    = head.kind;
	assign result.out_byte       = head.bytes[idx_q];
	assign result.decoded_length = head.len;
	assign result.last           = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (fire) begin
			idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

// ----- design/json_string_unescaper.sv -----
// ----------------------------------------------------------------------------
// JSON string unescaper
// Throughput: one input beat per cycle while the queue is not full and each beat
// yields at most one result; a beat that yields n UTF-8 bytes is sent as n result
// beats, and a four-group queue between decoder and serializer absorbs the
// difference. Each group is written into the queue when its beat is accepted.
// Reset: arst_n clears the decoder to idle and empties the queue at once.
// ----------------------------------------------------------------------------
module json_string_unescaper import jsu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	jsu_in_if.sink    text,
	jsu_out_if.source result
);

	logic     push;
	logic     full;
	logic     pop;
	logic     empty;
	res_grp_t wgrp;
	res_grp_t head;

	jsu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.push   (push),
		.grp    (wgrp),
		.full   (full)
	);

	jsu_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wgrp),
		.full   (full),
		.pop    (pop),
		.rdata  (head),
		.empty  (empty)
	);

	jsu_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule

// ----- design/jsu_checker.sv -----
// ----------------------------------------------------------------------------
// Unescaper port checker
// Watches the result channel for consistency of kind, payload and last.
// ----------------------------------------------------------------------------
module jsu_checker import jsu_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic [1:0]  result_kind,
	input logic [7:0]  out_byte,
	input logic [15:0] decoded_length,
	input logic        last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(result_kind) && $stable(out_byte)
			&& $stable(decoded_length) && $stable(last))
		else $error("result beat changed while stalled");

	// End and error results are always alone in their group.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (result_kind == KIND_END || result_kind == KIND_ERR) |-> last)
		else $error("end or error result without last");

	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (result_kind == KIND_DATA && decoded_length == 16'd0)
			|| (result_kind == KIND_END && out_byte == 8'd0)
			|| (result_kind == KIND_ERR && out_byte == 8'd0 && decoded_length == 16'd0))
		else $error("result fields do not match the kind");

	// A beat taken without last is always followed right away by another data beat.
	a_group: assert property (@(posedge clk) disable iff (!arst_n)
		valid && ready && !last |=> valid && result_kind == KIND_DATA)
		else $error("result group broken before its last beat");

endmodule

bind json_string_unescaper jsu_checker u_jsu_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.valid          (result.valid),
	.ready          (result.ready),
	.result_kind    (result.result_kind),
	.out_byte       (result.out_byte),
	.decoded_length (result.decoded_length),
	.last           (result.last)
);

// ----- dv/json_string_unescaper_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JSON string unescaper testbench
// Feeds directed and random JSON string tokens, well formed and broken, with
// random gaps on the text side and random stalls on the result side. Every
// result beat is predicted in the bench and checked in order.
// ----------------------------------------------------------------------------
module json_string_unescaper_tb;
	import jsu_pkg::*;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_END  = 1'b1;

	localparam logic [7:0] CTL_BACKSPACE = 8'h08;
	localparam logic [7:0] CTL_TAB       = 8'h09;
	localparam logic [7:0] CTL_NEWLINE   = 8'h0a;
	localparam logic [7:0] CTL_FORMFEED  = 8'h0c;
	localparam logic [7:0] CTL_RETURN    = 8'h0d;

	localparam int IDLE_PCT       = 17;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_BEATS   = 220;

	typedef struct packed {
		logic       op;
		logic [7:0] data;
	} text_beat_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic [15:0] len;
		logic        last;
	} decoded_t;

	logic clk;
	logic arst_n;

	jsu_in_if  text();
	jsu_out_if result();

	json_string_unescaper dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.result (result)
	);

	text_beat_t text_q[$];
	decoded_t   decoded_q[$];

	int   errors;
	int   beats_in;
	int   quiet_cycles;
	logic text_taken;
	logic calm;

	// Decoder state as the bench sees it.
	mode_t       str_mode;
	logic [15:0] hex_acc;
	logic [1:0]  hex_digits;
	logic [9:0]  high_half;
	logic [23:0] raw_held;
	logic [1:0]  raw_need;
	logic [1:0]  raw_count;
	logic [15:0] out_len;

	assign calm = (beats_in >= 120) && (beats_in < 200);

	always #5 clk = ~clk;

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - 8'h30;
		if (c >= "a" && c <= "f") return int'(c) - 8'h61 + 10;
		if (c >= "A" && c <= "F") return int'(c) - 8'h41 + 10;
		return -1;
	endfunction

	function automatic int utf8_form(input logic [20:0] cp, output logic [3:0][7:0] seq);
		seq = '0;
		if (cp < 21'h80) begin
			seq[0] = cp[7:0];
			return 1;
		end
		if (cp < 21'h800) begin
			seq[0] = 8'hc0 | 8'(cp >> 6);
			seq[1] = 8'h80 | 8'(cp & 21'h3f);
			return 2;
		end
		if (cp < 21'h10000) begin
			seq[0] = 8'he0 | 8'(cp >> 12);
			seq[1] = 8'h80 | 8'((cp >> 6) & 21'h3f);
			seq[2] = 8'h80 | 8'(cp & 21'h3f);
			return 3;
		end
		seq[0] = 8'hf0 | 8'((cp >> 18) & 21'h7);
		seq[1] = 8'h80 | 8'((cp >> 12) & 21'h3f);
		seq[2] = 8'h80 | 8'((cp >> 6) & 21'h3f);
		seq[3] = 8'h80 | 8'(cp & 21'h3f);
		return 4;
	endfunction

	function automatic void clear_decoder();
		str_mode = M_IDLE;
		hex_acc = '0;
		hex_digits = '0;
		high_half = '0;
		raw_held = '0;
		raw_need = '0;
		raw_count = '0;
		out_len = '0;
	endfunction

	function automatic void push_result(input logic [1:0] kind, input logic [7:0] data,
		input logic [15:0] len);
		decoded_t r;
		r.kind = kind;
		r.data = data;
		r.len = len;
		r.last = 1'b0;
		decoded_q.push_back(r);
	endfunction

	function automatic void emit_data(input logic [7:0] b);
		push_result(KIND_DATA, b, 16'h0000);
		if (out_len != LENGTH_MAX) out_len++;
	endfunction

	function automatic void reject();
		push_result(KIND_ERR, 8'h00, 16'h0000);
		clear_decoder();
	endfunction

	function automatic void emit_code(input logic [20:0] cp);
		logic [3:0][7:0] seq;
		int n;
		n = utf8_form(cp, seq);
		for (int i = 0; i < n; i++) emit_data(seq[i]);
	endfunction

	// Shifts in one hex digit; returns 1 once the fourth digit is in.
	function automatic logic take_digit(input logic [7:0] b, output logic bad);
		int d;
		d = hex_nibble(b);
		bad = (d < 0);
		if (bad) return 1'b0;
		hex_acc = {hex_acc[11:0], 4'(d)};
		if (hex_digits == 2'd3) begin
			hex_digits = 2'd0;
			return 1'b1;
		end
		hex_digits++;
		return 1'b0;
	endfunction

	function automatic void string_char(input logic [7:0] b);
		logic [1:0] need;
		if (b == CH_QUOTE) begin
			push_result(KIND_END, 8'h00, out_len);
			clear_decoder();
		end else if (b < 8'h20) begin
			reject();
		end else if (b == CH_BSLASH) begin
			str_mode = M_ESC;
		end else if (b >= 8'h80) begin
			if (b >= 8'hc2 && b <= 8'hdf) need = 2'd1;
			else if (b >= 8'he0 && b <= 8'hef) need = 2'd2;
			else if (b >= 8'hf0 && b <= 8'hf4) need = 2'd3;
			else begin
				reject();
				return;
			end
			raw_held = {16'h0000, b};
			raw_count = 2'd1;
			raw_need = need;
			str_mode = M_UTF8;
		end else begin
			emit_data(b);
		end
	endfunction

	// A raw multibyte sequence is only judged once its last byte is in.
	function automatic void raw_cont(input logic [7:0] b);
		int total;
		logic [31:0] seq;
		logic [7:0] part [4];
		logic [20:0] cp;
		if (b[7:6] != 2'b10 || raw_count == 2'd0) begin
			reject();
			return;
		end
		if (raw_need > 2'd1) begin
			raw_held = {raw_held[15:0], b};
			raw_count++;
			raw_need--;
			return;
		end
		total = int'(raw_count) + 1;
		seq = {raw_held, b};
		for (int i = 0; i < total; i++) part[i] = 8'(seq >> (8 * (total - 1 - i)));
		cp = 21'(part[0] & (total == 2 ? 8'h1f : total == 3 ? 8'h0f : 8'h07));
		for (int i = 1; i < total; i++) cp = (cp << 6) | 21'(part[i][5:0]);
		if ((total == 3 && cp < 21'h800) || (total == 4 && cp < 21'h10000) ||
			cp > 21'h10ffff || (cp >= 21'hd800 && cp <= 21'hdfff)) begin
			reject();
			return;
		end
		for (int i = 0; i < total; i++) emit_data(part[i]);
		raw_held = '0;
		raw_count = '0;
		raw_need = '0;
		str_mode = M_STR;
	endfunction

	function automatic void unescape_beat(input logic op, input logic [7:0] b);
		int first;
		logic bad;
		logic [15:0] code;
		decoded_t r;
		first = decoded_q.size();
		if (op == OP_END) begin
			reject();
		end else begin
			case (str_mode)
				M_IDLE: begin
					if (b == CH_QUOTE) begin
						clear_decoder();
						str_mode = M_STR;
					end else begin
						reject();
					end
				end
				M_STR: string_char(b);
				M_ESC: begin
					str_mode = M_STR;
					case (b)
						CH_QUOTE, CH_BSLASH, CH_SLASH: emit_data(b);
						CH_LB: emit_data(CTL_BACKSPACE);
						CH_LF: emit_data(CTL_FORMFEED);
						CH_LN: emit_data(CTL_NEWLINE);
						CH_LR: emit_data(CTL_RETURN);
						CH_LT: emit_data(CTL_TAB);
						CH_LU: begin
							hex_acc = '0;
							hex_digits = '0;
							str_mode = M_HEX;
						end
						default: reject();
					endcase
				end
				M_HEX: begin
					if (take_digit(b, bad)) begin
						code = hex_acc;
						hex_acc = '0;
						if (code >= 16'hd800 && code <= 16'hdbff) begin
							high_half = 10'(code - 16'hd800);
							str_mode = M_WAIT_BS;
						end else if (code >= 16'hdc00 && code <= 16'hdfff) begin
							reject();
						end else begin
							emit_code({5'b0, code});
							str_mode = M_STR;
						end
					end else if (bad) begin
						reject();
					end
				end
				M_WAIT_BS: begin
					if (b == CH_BSLASH) str_mode = M_WAIT_U;
					else reject();
				end
				M_WAIT_U: begin
					if (b == CH_LU) begin
						hex_acc = '0;
						hex_digits = '0;
						str_mode = M_HEX_LOW;
					end else begin
						reject();
					end
				end
				M_HEX_LOW: begin
					if (take_digit(b, bad)) begin
						code = hex_acc;
						hex_acc = '0;
						if (code < 16'hdc00 || code > 16'hdfff) begin
							reject();
						end else begin
							emit_code(21'h10000 + {high_half, 10'h000} + 21'(code - 16'hdc00));
							high_half = '0;
							str_mode = M_STR;
						end
					end else if (bad) begin
						reject();
					end
				end
				M_UTF8: raw_cont(b);
				default: reject();
			endcase
		end
		if (decoded_q.size() > first) begin
			r = decoded_q.pop_back();
			r.last = 1'b1;
			decoded_q.push_back(r);
		end
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------------
	function automatic void put_beat(input logic op, input logic [7:0] b);
		text_beat_t t;
		t.op = op;
		t.data = b;
		text_q.push_back(t);
	endfunction

	function automatic void put_char(input logic [7:0] b);
		put_beat(OP_BYTE, b);
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] cont_byte();
		return 8'h80 | 8'($urandom_range(0, 63));
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return 8'h30 + 8'(n);
		return (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
	endfunction

	function automatic void put_hex16(input logic [15:0] v);
		for (int i = 3; i >= 0; i--) put_char(hex_char(v[4 * i +: 4]));
	endfunction

	function automatic logic [7:0] plain_char();
		logic [7:0] b;
		do b = 8'($urandom_range(8'h20, 8'h7f));
		while (b == CH_QUOTE || b == CH_BSLASH);
		return b;
	endfunction

	function automatic logic escape_letter(input logic [7:0] b);
		return b inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LB, CH_LF, CH_LN, CH_LR, CH_LT,
			CH_LU};
	endfunction

	function automatic logic [7:0] escape_pick();
		case ($urandom_range(0, 7))
			0: return CH_QUOTE;
			1: return CH_BSLASH;
			2: return CH_SLASH;
			3: return CH_LB;
			4: return CH_LF;
			5: return CH_LN;
			6: return CH_LR;
			default: return CH_LT;
		endcase
	endfunction

	function automatic logic [7:0] non_hex();
		logic [7:0] b;
		do b = rand_byte();
		while (hex_nibble(b) >= 0);
		return b;
	endfunction

	function automatic void put_u_prefix();
		put_char(CH_BSLASH);
		put_char(CH_LU);
	endfunction

	function automatic void add_bmp();
		logic [15:0] cp;
		case ($urandom_range(0, 2))
			0: cp = 16'($urandom_range(0, 16'h7f));
			1: cp = 16'($urandom_range(16'h80, 16'h7ff));
			default: cp = 16'($urandom_range(16'h800, 16'hffff));
		endcase
		if (cp >= 16'hd800 && cp <= 16'hdfff) cp ^= 16'h4000;
		put_u_prefix();
		put_hex16(cp);
	endfunction

	function automatic void add_pair();
		put_u_prefix();
		put_hex16(16'hd800 + 16'($urandom_range(0, 16'h3ff)));
		put_u_prefix();
		put_hex16(16'hdc00 + 16'($urandom_range(0, 16'h3ff)));
	endfunction

	function automatic void add_raw();
		logic [20:0] cp;
		logic [3:0][7:0] seq;
		int n;
		case ($urandom_range(0, 2))
			0: cp = 21'($urandom_range(21'h80, 21'h7ff));
			1: begin
				cp = 21'($urandom_range(21'h800, 21'hffff));
				if (cp >= 21'hd800 && cp <= 21'hdfff) cp ^= 21'h4000;
			end
			default: cp = 21'($urandom_range(21'h10000, 21'h10ffff));
		endcase
		n = utf8_form(cp, seq);
		for (int i = 0; i < n; i++) put_char(seq[i]);
	endfunction

	// Each fault leaves the block idle, so the string stops here.
	function automatic void add_fault();
		logic [7:0] b;
		int k;
		case ($urandom_range(0, 10))
			0: put_char(8'($urandom_range(0, 31)));
			1: begin
				put_char(CH_BSLASH);
				do b = rand_byte();
				while (escape_letter(b));
				put_char(b);
			end
			2: begin
				put_u_prefix();
				repeat ($urandom_range(0, 3)) put_char(hex_char(4'($urandom_range(0, 15))));
				put_char(non_hex());
			end
			3: begin
				put_u_prefix();
				put_hex16(16'hdc00 + 16'($urandom_range(0, 16'h3ff)));
			end
			4: begin
				put_u_prefix();
				put_hex16(16'hd800 + 16'($urandom_range(0, 16'h3ff)));
				case ($urandom_range(0, 3))
					0: begin
						do b = rand_byte();
						while (b == CH_BSLASH);
						put_char(b);
					end
					1: begin
						put_char(CH_BSLASH);
						do b = rand_byte();
						while (b == CH_LU);
						put_char(b);
					end
					2: begin
						put_u_prefix();
						if ($urandom_range(0, 1) != 0)
							put_hex16(16'($urandom_range(0, 16'hdbff)));
						else
							put_hex16(16'($urandom_range(16'he000, 16'hffff)));
					end
					default: begin
						put_u_prefix();
						repeat ($urandom_range(0, 3))
							put_char(hex_char(4'($urandom_range(0, 15))));
						put_char(non_hex());
					end
				endcase
			end
			5: begin
				if ($urandom_range(0, 1) != 0) put_char(8'($urandom_range(8'h80, 8'hc1)));
				else put_char(8'($urandom_range(8'hf5, 8'hff)));
			end
			6: begin
				k = $urandom_range(1, 3);
				case (k)
					1: put_char(8'($urandom_range(8'hc2, 8'hdf)));
					2: put_char(8'($urandom_range(8'he0, 8'hef)));
					default: put_char(8'($urandom_range(8'hf0, 8'hf4)));
				endcase
				repeat ($urandom_range(0, k - 1)) put_char(cont_byte());
				do b = rand_byte();
				while (b[7:6] == 2'b10);
				put_char(b);
			end
			7: begin
				if ($urandom_range(0, 1) != 0) begin
					put_char(8'he0);
					put_char(8'($urandom_range(8'h80, 8'h9f)));
					put_char(cont_byte());
				end else begin
					put_char(8'hf0);
					put_char(8'($urandom_range(8'h80, 8'h8f)));
					put_char(cont_byte());
					put_char(cont_byte());
				end
			end
			8: begin
				put_char(8'hed);
				put_char(8'($urandom_range(8'ha0, 8'hbf)));
				put_char(cont_byte());
			end
			9: begin
				put_char(8'hf4);
				put_char(8'($urandom_range(8'h90, 8'hbf)));
				put_char(cont_byte());
				put_char(cont_byte());
			end
			default: put_beat(OP_END, rand_byte());
		endcase
	endfunction

	function automatic void add_string();
		int n;
		int pick;
		put_char(CH_QUOTE);
		n = $urandom_range(0, 10);
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				put_char(plain_char());
			end else if (pick < 55) begin
				put_char(CH_BSLASH);
				put_char(escape_pick());
			end else if (pick < 67) begin
				add_bmp();
			end else if (pick < 75) begin
				add_pair();
			end else if (pick < 95) begin
				add_raw();
			end else begin
				add_fault();
				return;
			end
		end
		// Most strings close; a few run into the end of the text.
		if ($urandom_range(0, 19) == 0) put_beat(OP_END, rand_byte());
		else put_char(CH_QUOTE);
	endfunction

	// Stray bytes or end-of-text beats between strings, before any opening quote.
	function automatic void add_noise();
		logic [7:0] b;
		if ($urandom_range(0, 99) < 15) begin
			if ($urandom_range(0, 2) == 0) begin
				put_beat(OP_END, rand_byte());
			end else begin
				do b = rand_byte();
				while (b == CH_QUOTE);
				put_char(b);
			end
		end
	endfunction

	// ------------------------------------------------------------------------
	// Text driver and result stall, both changing at the falling edge
	// ------------------------------------------------------------------------
	always @(negedge clk) begin : drive_text
		text_beat_t beat;
		if (arst_n) begin
			if (!text.valid || text_taken) begin
				if (text_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					beat = text_q.pop_front();
					text.valid <= 1'b1;
					text.opcode <= beat.op;
					text.in_byte <= beat.data;
				end else begin
					text.valid <= 1'b0;
				end
			end
			result.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// ------------------------------------------------------------------------
	// Result check, prediction and watchdog at the rising edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		decoded_t got;
		decoded_t want;
		string    got_txt;
		string    want_txt;
		if (!arst_n) begin
			text_taken <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			text_taken <= text.valid && text.ready;
			// Check before predicting: a result never comes from the beat taken at
			// this same edge.
			if (result.valid && result.ready) begin
				got.kind = result.result_kind;
				got.data = result.out_byte;
				got.len = result.decoded_length;
				got.last = result.last;
				got_txt = $sformatf("kind %0d byte %02h len %0d last %0b",
					got.kind, got.data, got.len, got.last);
				if (decoded_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat, expected none, got %s", $time, got_txt);
				end else begin
					want = decoded_q.pop_front();
					if (got !== want) begin
						errors++;
						want_txt = $sformatf("kind %0d byte %02h len %0d last %0b",
							want.kind, want.data, want.len, want.last);
						$display("%0t: mismatch, expected %s, got %s", $time, want_txt,
							got_txt);
					end
				end
			end
			if (text.valid && text.ready) begin
				unescape_beat(text.opcode, text.in_byte);
				beats_in <= beats_in + 1;
			end
			if ((text.valid && text.ready) || (result.valid && result.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int base;
		clk = 1'b0;
		arst_n = 1'b0;
		text.valid = 1'b0;
		text.opcode = OP_BYTE;
		text.in_byte = 8'h00;
		result.ready = 1'b0;
		errors = 0;
		beats_in = 0;
		quiet_cycles = 0;
		text_taken = 1'b0;
		clear_decoder();

		// Directed: a byte before an opening quote, an end of text while idle, the
		// largest BMP escape, the largest surrogate pair and a bad raw lead byte.
		put_char(8'h00);
		put_beat(OP_END, 8'hff);
		put_char(CH_QUOTE);
		put_char(8'h7f);
		put_u_prefix();
		put_hex16(16'hffff);
		put_u_prefix();
		put_hex16(16'hdbff);
		put_u_prefix();
		put_hex16(16'hdfff);
		put_char(CH_QUOTE);
		put_char(CH_QUOTE);
		put_char(8'hff);

		base = text_q.size();
		while (text_q.size() < base + RANDOM_BEATS) begin
			add_noise();
			add_string();
		end

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		while (text_q.size() != 0 || text.valid) @(posedge clk);
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		if (errors == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

endmodule
